@@ hdl/mfps_pkg.sv @@
// shared constants for the minimum falling path sum block
// no dependencies; imported by min_falling_path_sum and mfps_row_ram
package mfps_pkg;

  localparam int CFG_W         = 9;
  localparam int SUM_W         = 24;
  localparam int DEF_MAX_SIDE  = 256;
  localparam int DEF_CELL_BITS = 16;

  // running minimum starts at the largest positive sum
  localparam logic signed [SUM_W-1:0] MIN_INIT = {1'b0, {(SUM_W-1){1'b1}}};

endpackage

@@ hdl/mfps_row_ram.sv @@
// previous-row store: one write port, one registered read port, with
// write-to-read forwarding on a same-address collision; uses mfps_pkg
module mfps_row_ram
  import mfps_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_SIDE,
  parameter int ADDR_W = 8
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic signed [SUM_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [ADDR_W-1:0]       rd_addr,
  output logic signed [SUM_W-1:0] rd_data
);

  logic signed [SUM_W-1:0] mem [DEPTH];
  logic signed [SUM_W-1:0] q_r;
  logic signed [SUM_W-1:0] fwd_data_r;
  logic                    fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  // read during write returns the word being written
  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

@@ hdl/min_falling_path_sum.sv @@
// minimum falling path sum over a square matrix streamed one cell per word
// depends on mfps_pkg and mfps_row_ram
//
//  channel | ports                               | direction | word
//  --------+-------------------------------------+-----------+----------------------
//  in      | in_valid in_ready in_cell_value      | input     | one cell, row-major
//  out     | out_valid out_ready out_min_path_sum | output    | one sum per matrix
//  cfg     | cfg_wr_en cfg_wr_data                | input     | matrix side length
//
// one cell a cycle; at accept the previous-row word to the right of the cell is read
// from the row ram, and the cell is combined and written back the next cycle, so the
// ram's single read port sets the rate. a matrix sum passes from stage 1 into the
// registered output buffer; a two-word output buffer lets matrices follow with no gap,
// and a last cell waits only while two sums would still be held at the next edge.
// synchronous active-low reset; the row ram needs no clearing pass.
module min_falling_path_sum
  import mfps_pkg::*;
#(
  parameter int MAX_SIDE  = DEF_MAX_SIDE,
  parameter int CELL_BITS = DEF_CELL_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [CELL_BITS-1:0] in_cell_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SUM_W-1:0]     out_min_path_sum,
  input  logic                        cfg_wr_en,
  input  logic [CFG_W-1:0]            cfg_wr_data
);

  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic [IDX_W-1:0] col_r, row_r;
  logic             in_fire, at_last_col, at_last_row;
  logic [CMP_W-1:0] side_ext;

  // stage 1: combine and write back
  logic                        s1_valid_r;
  logic signed [CELL_BITS-1:0] s1_cell_r;
  logic [IDX_W-1:0]            s1_col_r;
  logic                        s1_first_row_r, s1_last_row_r, s1_last_col_r;
  logic                        s1_done;

  logic signed [SUM_W-1:0] left_r, mid_r, first_r;
  logic signed [SUM_W-1:0] mid_val, right_val, best, cell_ext, stored;
  logic signed [SUM_W-1:0] min_r, min_nxt;

  // two-word output buffer: head drives the port, skid sits behind it
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic                    sk_valid_r, sk_valid_nxt;
  logic signed [SUM_W-1:0] sk_sum_r, sk_sum_nxt;
  logic                    out_pop;
  logic [1:0]              out_load;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  assign at_last_col = (col_r == last_idx_r);
  assign at_last_row = (row_r == last_idx_r);
  assign s1_done     = s1_valid_r && s1_last_row_r && s1_last_col_r;
  assign out_pop     = out_valid_r && out_ready;

  // words held at the next edge, counting a sum in flight and one leaving now
  assign out_load = {1'b0, out_valid_r} + {1'b0, sk_valid_r} + {1'b0, s1_done}
                  - {1'b0, out_pop};

  // a last cell needs a free output word when it reaches stage 1
  assign in_ready = !(at_last_row && at_last_col && (out_load > 2'd1));
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    side_ext = CMP_W'(cfg_wr_data);
    if (side_ext == '0) begin
      last_idx_nxt = '0;
    end else if (side_ext > CMP_W'(MAX_SIDE)) begin
      last_idx_nxt = IDX_W'(MAX_SIDE - 1);
    end else begin
      last_idx_nxt = IDX_W'(side_ext - CMP_W'(1));
    end
  end

  assign rd_en   = in_fire && !at_last_col;
  assign rd_addr = col_r + IDX_W'(1);

  mfps_row_ram #(
    .DEPTH  (MAX_SIDE),
    .ADDR_W (IDX_W)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (stored),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (right_val)
  );

  always_comb begin
    cell_ext = SUM_W'(s1_cell_r);
    mid_val  = (s1_col_r == '0) ? first_r : mid_r;
    best     = mid_val;
    if ((s1_col_r != '0) && (left_r < best)) begin
      best = left_r;
    end
    if (!s1_last_col_r && (right_val < best)) begin
      best = right_val;
    end
    stored = s1_first_row_r ? cell_ext : cell_ext + best;
    min_nxt = min_r;
    if (s1_last_row_r && ((s1_col_r == '0) || (stored < min_r))) begin
      min_nxt = stored;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    sk_valid_nxt  = sk_valid_r;
    sk_sum_nxt    = sk_sum_r;
    if (out_pop) begin
      out_valid_nxt = sk_valid_r;
      out_sum_nxt   = sk_sum_r;
      sk_valid_nxt  = 1'b0;
    end
    if (s1_done) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = min_nxt;
      end else begin
        sk_valid_nxt = 1'b1;
        sk_sum_nxt   = min_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      min_r       <= MIN_INIT;
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      s1_valid_r  <= in_fire;
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
      if (cfg_wr_en) begin
        last_idx_r <= last_idx_nxt;
        col_r      <= '0;
        row_r      <= '0;
        min_r      <= MIN_INIT;
      end else begin
        if (in_fire) begin
          if (at_last_col) begin
            col_r <= '0;
            row_r <= at_last_row ? '0 : row_r + IDX_W'(1);
          end else begin
            col_r <= col_r + IDX_W'(1);
          end
        end
        if (s1_valid_r) begin
          min_r <= s1_done ? MIN_INIT : min_nxt;
        end
      end
    end
  end

  // payload and window registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r      <= in_cell_value;
      s1_col_r       <= col_r;
      s1_first_row_r <= (row_r == '0);
      s1_last_row_r  <= at_last_row;
      s1_last_col_r  <= at_last_col;
    end
    if (s1_valid_r) begin
      left_r <= mid_val;
      mid_r  <= right_val;
      if (s1_col_r == '0) begin
        first_r <= stored;
      end
    end
    out_sum_r <= out_sum_nxt;
    sk_sum_r  <= sk_sum_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_min_path_sum = out_sum_r;

`ifndef SYNTH
  a_sum_finds_free_word: assert property (@(posedge clk) disable iff (!rst_n)
    s1_done |-> !sk_valid_r)
    else $error("matrix sum arrived with the output buffer full");

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid word held with an empty head");

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= last_idx_r) && (row_r <= last_idx_r))
    else $error("cell counters beyond the matrix side");

  a_sum_follows_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_done))
    else $error("sum raised without a finished matrix");

  a_stage1_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted cell did not reach the combine stage");
`endif

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for min_falling_path_sum: a table of directed words,
// then random matrices under four idle mixes, each checked against a local model
// depends on mfps_pkg and the min_falling_path_sum rtl only
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mfps_pkg::*;

  localparam int SIDE_MAX      = DEF_MAX_SIDE;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_CELLS     = 120;

  typedef logic signed [DEF_CELL_BITS-1:0] cell_t;
  typedef logic signed [SUM_W-1:0]         sum_t;

  localparam cell_t CELL_MIN = {1'b1, {(DEF_CELL_BITS-1){1'b0}}};
  localparam cell_t CELL_MAX = {1'b0, {(DEF_CELL_BITS-1){1'b1}}};

  typedef enum logic [1:0] {OP_SIDE, OP_CELL, OP_RAND_CELL} stim_op_t;

  typedef struct {
    stim_op_t op;
    int       arg;
    int       reps;
    bit       typed;
    int       sum;
  } stim_row_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  cell_t              in_cell_value = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  sum_t               out_min_path_sum;
  logic               cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data   = '0;

  // path sum model state
  sum_t               prev_row [SIDE_MAX];
  sum_t               cur_row  [SIDE_MAX];
  int unsigned        col_pos   = 0;
  int unsigned        row_pos   = 0;
  sum_t               run_min   = MIN_INIT;
  logic [CFG_W-1:0]   side_reg  = 1;

  sum_t               pending_sums [$];
  sum_t               head_sum;
  int                 in_idle_pct   = 0;
  int                 out_stall_pct = 0;
  int                 mismatch_count = 0;
  int                 cells_sent     = 0;
  int                 sums_checked   = 0;
  int                 side_writes    = 0;

  stim_row_t dir_tab [21] = '{
    '{OP_CELL,      32767,  1,     1'b1, 32767},    // side one out of reset
    '{OP_CELL,      -32768, 1,     1'b1, -32768},
    '{OP_SIDE,      0,      1,     1'b0, 0},        // zero side acts as one
    '{OP_CELL,      5,      1,     1'b1, 5},
    '{OP_SIDE,      2,      1,     1'b0, 0},
    '{OP_CELL,      10,     1,     1'b0, 0},
    '{OP_CELL,      -3,     1,     1'b0, 0},
    '{OP_CELL,      4,      1,     1'b0, 0},
    '{OP_CELL,      8,      1,     1'b1, 1},
    '{OP_SIDE,      3,      1,     1'b0, 0},
    '{OP_RAND_CELL, 0,      7,     1'b0, 0},        // dropped by the next write
    '{OP_SIDE,      2,      1,     1'b0, 0},
    '{OP_RAND_CELL, 0,      4,     1'b0, 0},
    '{OP_SIDE,      3,      1,     1'b0, 0},
    '{OP_RAND_CELL, 0,      9,     1'b0, 0},
    '{OP_CELL,      -32768, 9,     1'b1, -98304},
    '{OP_SIDE,      8,      1,     1'b0, 0},
    '{OP_CELL,      -32768, 64,    1'b1, -262144},
    '{OP_CELL,      32767,  64,    1'b1, 262136},
    '{OP_SIDE,      511,    1,     1'b0, 0},        // clamps to the largest side
    '{OP_RAND_CELL, 0,      260,   1'b0, 0}         // wraps rows at 256 columns
  };

  min_falling_path_sum dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cell_value    (in_cell_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_min_path_sum (out_min_path_sum),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned side_now();
    if (side_reg == 0) return 1;
    if (side_reg > SIDE_MAX) return SIDE_MAX;
    return side_reg;
  endfunction

  function automatic void restart_matrix();
    col_pos = 0;
    row_pos = 0;
    run_min = MIN_INIT;
  endfunction

  // folds one cell into the model; returns 1 when it closes a matrix
  function automatic bit fold_cell(input cell_t v, output sum_t sum_out);
    int unsigned n;
    sum_t        best;
    sum_t        stored;
    bit          done;
    n       = side_now();
    done    = 1'b0;
    sum_out = '0;
    if (row_pos == 0) begin
      stored = sum_t'(v);
    end else begin
      best = prev_row[col_pos];
      if (col_pos > 0 && prev_row[col_pos-1] < best) best = prev_row[col_pos-1];
      if (col_pos + 1 < n && prev_row[col_pos+1] < best) best = prev_row[col_pos+1];
      stored = best + sum_t'(v);
    end
    cur_row[col_pos] = stored;
    if (row_pos + 1 == n && (col_pos == 0 || stored < run_min)) run_min = stored;
    if (col_pos + 1 == n) begin
      prev_row = cur_row;
      if (row_pos + 1 == n) begin
        sum_out = run_min;
        done    = 1'b1;
        restart_matrix();
      end else begin
        col_pos = 0;
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return done;
  endfunction

  function automatic cell_t random_cell();
    case ($urandom_range(9))
      0:       return CELL_MIN;
      1:       return CELL_MAX;
      2, 3:    return cell_t'(int'($urandom_range(8)) - 4);  // near ties
      default: return cell_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_side();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 55) return CFG_W'($urandom_range(4, 1));
    if (r < 85) return CFG_W'($urandom_range(8, 5));
    if (r < 97) return CFG_W'($urandom_range(16, 9));
    return CFG_W'($urandom_range(24, 17));
  endfunction

  task automatic send_cell(input cell_t v, input bit typed, input sum_t typed_sum);
    sum_t s;
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid      <= 1'b1;
    in_cell_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cells_sent++;
    if (fold_cell(v, s)) pending_sums.push_back(typed ? typed_sum : s);
  endtask

  // hold off the sender until every sum is out and the last cell has settled
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] side);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= side;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    side_reg = side;
    restart_matrix();
    side_writes++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        $error("min_path_sum: expected none, got %0d", out_min_path_sum);
        mismatch_count++;
      end else begin
        head_sum = pending_sums.pop_front();
        sums_checked++;
        if (out_min_path_sum !== head_sum) begin
          $error("min_path_sum: expected %0d, got %0d", head_sum, out_min_path_sum);
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    stim_row_t r;
    int        seg;
    int        cell_goal;
    int        n;
    int        cnt;
    int        roll;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.op == OP_SIDE) begin
        quiesce();
        write_side(CFG_W'(r.arg));
      end else begin
        repeat (r.reps)
          send_cell(r.op == OP_CELL ? cell_t'(r.arg) : random_cell(), r.typed, sum_t'(r.sum));
      end
    end

    cell_goal = cells_sent;
    for (seg = 0; seg < 8; seg++) begin
      quiesce();
      case (seg % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 54; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 54; end
        default: begin in_idle_pct = 31; out_stall_pct = 31; end
      endcase
      write_side(pick_side());
      cell_goal += SEG_CELLS;
      while (cells_sent < cell_goal) begin
        n    = side_now();
        roll = $urandom_range(99);
        if (roll < 10 && n > 1) begin
          // broken matrix, dropped by a side write
          cnt = $urandom_range(n * n - 1, 1);
          repeat (cnt) send_cell(random_cell(), 1'b0, '0);
          quiesce();
          write_side(pick_side());
        end else begin
          cnt = n * n;
          repeat (cnt) send_cell(random_cell(), 1'b0, '0);
          if (roll < 25) begin
            quiesce();
          end else if (roll < 35) begin
            quiesce();
            write_side(pick_side());
          end
        end
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    $display("%0d cells over %0d side writes, %0d matrix sums compared", cells_sent,
             side_writes, sums_checked);
    $display("cell extremes, clamped and zero sides, dropped matrices, four idle mixes");
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mfps_pkg.sv
hdl/mfps_row_ram.sv
hdl/min_falling_path_sum.sv
dv/tb_top.sv
